>>> design/ssg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssg_pkg;

	// Command codes carried in the input tuser
	typedef enum logic [2:0] {
		OP_BEGIN     = 3'd0,
		OP_GROUP     = 3'd1,
		OP_PIXEL     = 3'd2,
		OP_HEARTBEAT = 3'd3,
		OP_END       = 3'd4,
		OP_CANCEL    = 3'd5,
		OP_TMO_CHECK = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_BAD_ARG       = 3'd1,
		ST_NOT_ACTIVE    = 3'd2,
		ST_WRONG_ID      = 3'd3,
		ST_MODE_MISMATCH = 3'd4,
		ST_STALE         = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_GROUP = 2'd1,
		MODE_PIXEL = 2'd2
	} mode_t;

	localparam int unsigned IN_TDATA_W  = 88;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

	typedef struct packed {
		logic        active;
		logic [31:0] held_id;
		mode_t       mode;
		logic [15:0] prev_seq;
		logic        seq_seen;
		logic [31:0] last_touch;
	} gate_state_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] sess_id;
		logic [15:0] seq_num;
		logic [31:0] now_time;
		logic        payload_ok;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic    accept_payload;
		logic    timed_out;
		mode_t   cur_mode;
	} result_t;

endpackage

`default_nettype wire

>>> design/stream_session_gate.sv
`timescale 1ns / 1ps
`default_nettype none

// Session gate for a streamed lighting-control link.
// Input stream (s_*): one command transaction per item. s_tuser holds the
// command code; s_tdata holds session id, sequence number, current time
// and the outside payload-valid flag. Every command yields exactly one
// result transaction on the output stream (m_*): status, accept flag for
// the frame payload, timeout flag and the mode after the command.
//
// Configuration (cfg_*): a separate write channel for the inactivity
// timeout in ms. It is always ready; write it only while the gate is idle.
//
// A command is held in the input register, then the decision logic feeds
// the result register. Throughput is one command per cycle while m_tready
// keeps the result register draining; the session state is read and
// updated in the same cycle that a command moves into the result
// register, so back-to-back commands see each other's effects.
//
// Reset clears the session (inactive, no mode, no sequence seen, time 0)
// and loads the timeout with 3000 ms. When the receiver stalls, the
// result register holds, the input register fills, and then s_tready
// drops until the result is taken.
module stream_session_gate (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] sess_id, [47:32] seq_num, [79:48] now_time, [80] payload_ok,
	// [87:81] zero
	input  logic [ssg_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [2:0] op
	input  logic [2:0]                         s_tuser,
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] status, [3] accept_payload, [4] timed_out, [6:5] cur_mode,
	// [7] zero
	output logic [ssg_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// Configuration write channel: timeout_ms
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [31:0]                        cfg_data
);
	import ssg_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic        advance;
	logic [31:0] timeout_q;
	gate_state_t state_q;
	gate_state_t state_nxt;
	result_t     res_nxt;
	cmd_t        cmd_in;

	// Unpack the incoming transaction
	assign cmd_in.op         = op_t'(s_tuser);
	assign cmd_in.sess_id    = s_tdata[31:0];
	assign cmd_in.seq_num    = s_tdata[47:32];
	assign cmd_in.now_time   = s_tdata[79:48];
	assign cmd_in.payload_ok = s_tdata[80];

	// Move the held command into the result register when that register is
	// empty or being drained this cycle.
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= cmd_in;
		end
	end

	// Decision logic: checks and next session state for the held command
	ssg_step u_step (
		.cur        (state_q),
		.cmd        (cmd_s1),
		.timeout_ms (timeout_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Commit the session state only when the command's result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.active     <= 1'b0;
			state_q.held_id    <= 32'd0;
			state_q.mode       <= MODE_NONE;
			state_q.prev_seq   <= 16'd0;
			state_q.seq_seen   <= 1'b0;
			state_q.last_touch <= 32'd0;
		end else if (advance && valid_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// Timeout register; writes are taken at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.cur_mode, res_s2.timed_out,
		res_s2.accept_payload, res_s2.status};

	// A frame payload is only accepted with an ok status
	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.accept_payload) |-> (res_s2.status == ST_OK))
		else $error("payload accepted with non-ok status");

	// A timed-out session reports no mode
	a_tmo_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.timed_out) |-> (res_s2.cur_mode == MODE_NONE))
		else $error("timeout result with a locked mode");

	// An inactive session never keeps a locked mode or a seen sequence
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.active |-> (state_q.mode == MODE_NONE && !state_q.seq_seen))
		else $error("inactive session holds mode or sequence");

	// A result only appears after a command sat in the input register
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result without a held command");

endmodule

`default_nettype wire

>>> design/ssg_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ssg_step (
	input  ssg_pkg::gate_state_t cur,
	input  ssg_pkg::cmd_t        cmd,
	input  logic [31:0]          timeout_ms,
	output ssg_pkg::gate_state_t nxt,
	output ssg_pkg::result_t     res
);
	import ssg_pkg::*;

	logic [15:0] seq_diff;
	logic [31:0] idle_time;
	logic        id_match;
	logic        stale;
	mode_t       want_mode;

	assign seq_diff  = cmd.seq_num - cur.prev_seq;
	assign idle_time = cmd.now_time - cur.last_touch;
	assign id_match  = (cur.held_id == cmd.sess_id);
	assign stale     = cur.seq_seen && ((seq_diff == 16'd0) || seq_diff[15]);
	assign want_mode = (cmd.op == OP_GROUP) ? MODE_GROUP : MODE_PIXEL;

	always_comb begin
		nxt                = cur;
		res.status         = ST_OK;
		res.accept_payload = 1'b0;
		res.timed_out      = 1'b0;
		unique case (cmd.op)
			OP_BEGIN: begin
				if (cmd.sess_id == 32'd0) begin
					res.status = ST_BAD_ARG;
				end else begin
					nxt.active     = 1'b1;
					nxt.held_id    = cmd.sess_id;
					nxt.last_touch = cmd.now_time;
					nxt.prev_seq   = 16'd0;
					nxt.seq_seen   = 1'b0;
					nxt.mode       = MODE_NONE;
				end
			end
			OP_GROUP, OP_PIXEL: begin
				priority if (!cmd.payload_ok) begin
					res.status = ST_BAD_ARG;
				end else if (!cur.active) begin
					res.status = ST_NOT_ACTIVE;
				end else if (!id_match) begin
					res.status = ST_WRONG_ID;
				end else if (cur.mode != MODE_NONE && cur.mode != want_mode) begin
					res.status = ST_MODE_MISMATCH;
				end else if (stale) begin
					res.status = ST_STALE;
				end else begin
					nxt.mode           = want_mode;
					nxt.prev_seq       = cmd.seq_num;
					nxt.seq_seen       = 1'b1;
					nxt.last_touch     = cmd.now_time;
					res.accept_payload = 1'b1;
				end
			end
			OP_HEARTBEAT, OP_END: begin
				priority if (!cur.active) begin
					res.status = ST_NOT_ACTIVE;
				end else if (!id_match) begin
					res.status = ST_WRONG_ID;
				end else if (cmd.op == OP_HEARTBEAT) begin
					nxt.last_touch = cmd.now_time;
				end else begin
					nxt.active   = 1'b0;
					nxt.held_id  = 32'd0;
					nxt.seq_seen = 1'b0;
					nxt.mode     = MODE_NONE;
				end
			end
			OP_CANCEL: begin
				nxt.active   = 1'b0;
				nxt.held_id  = 32'd0;
				nxt.seq_seen = 1'b0;
				nxt.mode     = MODE_NONE;
			end
			OP_TMO_CHECK: begin
				if (cur.active && (idle_time >= timeout_ms)) begin
					nxt.active    = 1'b0;
					nxt.held_id   = 32'd0;
					nxt.seq_seen  = 1'b0;
					nxt.mode      = MODE_NONE;
					res.timed_out = 1'b1;
				end
			end
			default: begin
				res.status = ST_BAD_ARG;
			end
		endcase
		res.cur_mode = nxt.active ? nxt.mode : MODE_NONE;
	end

endmodule

`default_nettype wire
